### hw/rtl/ses_pkg.sv
// Shared types and codes for the sparse entry store.
package ses_pkg;

  // Field widths fixed by the interface
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned TOTAL_W = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 8'd1;

  // Request modes
  localparam logic MODE_READ = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Reset value of both bounds registers
  localparam logic [COUNT_W-1:0] COUNT_RESET = 17'h10000;

  // Control of the shared compare unit
  typedef struct packed {
    logic clear;
    logic en;
  } scan_ctl_t;

  // Write control of the slot memory
  typedef struct packed {
    logic we;
    logic set_valid;
    logic clr_valid;
  } mem_wr_t;

endpackage

### hw/rtl/ses_slot_mem.sv
// Slot memory: key and value arrays plus per-slot valid flags.
module ses_slot_mem #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned AW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ses_pkg::mem_wr_t            wr,
  input  logic [AW-1:0]               waddr,
  input  logic [ses_pkg::INDEX_W-1:0] wrow,
  input  logic [ses_pkg::INDEX_W-1:0] wcol,
  input  logic [ses_pkg::VALUE_W-1:0] wvalue,
  input  logic [AW-1:0]               raddr,
  output logic                        rd_valid,
  output logic [ses_pkg::INDEX_W-1:0] rd_row,
  output logic [ses_pkg::INDEX_W-1:0] rd_col,
  output logic [ses_pkg::VALUE_W-1:0] rd_value
);

  logic [ses_pkg::INDEX_W-1:0] row_mem [CAPACITY];
  logic [ses_pkg::INDEX_W-1:0] col_mem [CAPACITY];
  logic [ses_pkg::VALUE_W-1:0] val_mem [CAPACITY];
  logic [CAPACITY-1:0]         valid_r;
  logic                        rd_valid_r;
  logic [ses_pkg::INDEX_W-1:0] rd_row_r;
  logic [ses_pkg::INDEX_W-1:0] rd_col_r;
  logic [ses_pkg::VALUE_W-1:0] rd_value_r;

  // Array write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      row_mem[waddr] <= wrow;
      col_mem[waddr] <= wcol;
      val_mem[waddr] <= wvalue;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_row_r   <= row_mem[raddr];
    rd_col_r   <= col_mem[raddr];
    rd_value_r <= val_mem[raddr];
    rd_valid_r <= valid_r[raddr];
  end

  // Valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.set_valid) begin
      valid_r[waddr] <= 1'b1;
    end else if (wr.clr_valid) begin
      valid_r[waddr] <= 1'b0;
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_row   = rd_row_r;
  assign rd_col   = rd_col_r;
  assign rd_value = rd_value_r;

endmodule

### hw/rtl/ses_scan_unit.sv
// Shared key compare: finds the first matching slot and the first free slot.
module ses_scan_unit #(
  parameter int unsigned AW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ses_pkg::scan_ctl_t          ctl,
  input  logic [AW-1:0]               idx,
  input  logic                        slot_valid,
  input  logic [ses_pkg::INDEX_W-1:0] slot_row,
  input  logic [ses_pkg::INDEX_W-1:0] slot_col,
  input  logic [ses_pkg::VALUE_W-1:0] slot_value,
  input  logic [ses_pkg::INDEX_W-1:0] key_row,
  input  logic [ses_pkg::INDEX_W-1:0] key_col,
  output logic                        hit,
  output logic [AW-1:0]               hit_idx,
  output logic [ses_pkg::VALUE_W-1:0] hit_value,
  output logic                        free_found,
  output logic [AW-1:0]               free_idx
);

  logic                        hit_r;
  logic                        free_r;
  logic [AW-1:0]               hit_idx_r;
  logic [AW-1:0]               free_idx_r;
  logic [ses_pkg::VALUE_W-1:0] hit_value_r;
  logic                        match;
  logic                        take_hit;
  logic                        take_free;

  // One comparison per cycle while ctl.en is high
  assign match     = (slot_row == key_row) && (slot_col == key_col);
  assign take_hit  = ctl.en && slot_valid && match && !hit_r;
  assign take_free = ctl.en && !slot_valid && !free_r;

  // Found flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (ctl.clear) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      if (take_hit) begin
        hit_r <= 1'b1;
      end
      if (take_free) begin
        free_r <= 1'b1;
      end
    end
  end

  // Captured slot index and value
  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx_r   <= idx;
      hit_value_r <= slot_value;
    end
    if (take_free) begin
      free_idx_r <= idx;
    end
  end

  assign hit        = hit_r;
  assign hit_idx    = hit_idx_r;
  assign hit_value  = hit_value_r;
  assign free_found = free_r;
  assign free_idx   = free_idx_r;

endmodule

### hw/rtl/sparse_entry_store.sv
// Sparse entry store top level: request sequencer, bounds registers and result register.
//
//  channel | direction | handshake            | payload
//  in_     | request   | in_valid / in_ready   | mode, row, col, value
//  out_    | result    | out_valid / out_ready | read_value, found, status, entry_total
//  cfg_    | register  | cfg_valid / cfg_ready | index, data
//
// An in-range request passes through the scan, decide and response states before out_valid: the
// slot memory has one read port, so the scan reads one slot per cycle. An
// out-of-range request goes straight to the response state. in_ready is high only when idle, so
// a new request is not accepted before the last one is through; a finished result waits in the
// output register and the next request may be accepted then.
// Reset is synchronous; valid flags clear at once, no clearing pass is needed.
module sparse_entry_store #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [ses_pkg::INDEX_W-1:0]     in_row,
  input  logic [ses_pkg::INDEX_W-1:0]     in_col,
  input  logic [ses_pkg::VALUE_W-1:0]     in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ses_pkg::VALUE_W-1:0]     out_read_value,
  output logic                            out_found,
  output logic [ses_pkg::STATUS_W-1:0]    out_status,
  output logic [ses_pkg::TOTAL_W-1:0]     out_entry_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ses_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ses_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned TW  = $clog2(CAPACITY + 1);
  localparam int unsigned TWX = TW + ses_pkg::TOTAL_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         issue_r;
  logic [AW-1:0]                idx_r;
  logic [TW-1:0]                total_r, total_nxt;
  logic [ses_pkg::COUNT_W-1:0]  row_count_r;
  logic [ses_pkg::COUNT_W-1:0]  column_count_r;
  logic                         out_valid_r;

  // Latched request and pending result
  logic                         mode_r;
  logic [ses_pkg::INDEX_W-1:0]  row_r;
  logic [ses_pkg::INDEX_W-1:0]  col_r;
  logic [ses_pkg::VALUE_W-1:0]  value_r;
  logic [ses_pkg::VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                         res_found_r, res_found_nxt;
  logic [ses_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ses_pkg::VALUE_W-1:0]  out_read_value_r;
  logic                         out_found_r;
  logic [ses_pkg::STATUS_W-1:0] out_status_r;
  logic [ses_pkg::TOTAL_W-1:0]  out_entry_total_r;

  logic                         in_acc;
  logic                         range_bad;
  logic                         issue;
  logic                         load_out;
  logic                         value_zero;
  logic [TWX-1:0]               total_wide;

  ses_pkg::scan_ctl_t           scan_ctl;
  ses_pkg::mem_wr_t             mem_wr;
  logic [AW-1:0]                waddr;

  logic                         rd_valid;
  logic [ses_pkg::INDEX_W-1:0]  rd_row;
  logic [ses_pkg::INDEX_W-1:0]  rd_col;
  logic [ses_pkg::VALUE_W-1:0]  rd_value;
  logic                         hit;
  logic [AW-1:0]                hit_idx;
  logic [ses_pkg::VALUE_W-1:0]  hit_value;
  logic                         free_found;
  logic [AW-1:0]                free_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign range_bad = ({1'b0, in_row} >= row_count_r) || ({1'b0, in_col} >= column_count_r);
  assign issue     = (state_r == S_SCAN) && (cnt_r < CW'(CAPACITY));
  assign load_out  = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign value_zero = (value_r[ses_pkg::VALUE_W-2:0] == '0);

  assign scan_ctl.clear = in_acc;
  assign scan_ctl.en    = issue_r;

  ses_slot_mem #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (mem_wr),
    .waddr    (waddr),
    .wrow     (row_r),
    .wcol     (col_r),
    .wvalue   (value_r),
    .raddr    (cnt_r[AW-1:0]),
    .rd_valid (rd_valid),
    .rd_row   (rd_row),
    .rd_col   (rd_col),
    .rd_value (rd_value)
  );

  ses_scan_unit #(
    .AW (AW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .idx        (idx_r),
    .slot_valid (rd_valid),
    .slot_row   (rd_row),
    .slot_col   (rd_col),
    .slot_value (rd_value),
    .key_row    (row_r),
    .key_col    (col_r),
    .hit        (hit),
    .hit_idx    (hit_idx),
    .hit_value  (hit_value),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  // Sequencer and update decision
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    res_value_nxt  = res_value_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    mem_wr         = '0;
    waddr          = hit_idx;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt        = '0;
          res_value_nxt  = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = ses_pkg::ST_OK;
          if (range_bad) begin
            res_status_nxt = ses_pkg::ST_RANGE;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + CW'(1);
        end else if (!issue_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_found_nxt = hit;
        state_nxt     = S_RESP;
        if (mode_r == ses_pkg::MODE_READ) begin
          if (hit) begin
            res_value_nxt = hit_value;
          end
        end else if (value_zero) begin
          // a write whose low 63 bits are zero frees a matching entry
          if (hit) begin
            mem_wr.clr_valid = 1'b1;
            total_nxt        = total_r - TW'(1);
          end
        end else if (hit) begin
          mem_wr.we = 1'b1;
        end else if (free_found) begin
          // insert into the lowest free slot
          waddr            = free_idx;
          mem_wr.we        = 1'b1;
          mem_wr.set_valid = 1'b1;
          total_nxt        = total_r + TW'(1);
        end else begin
          res_status_nxt = ses_pkg::ST_FULL;
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      issue_r <= issue;
      total_r <= total_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Bounds registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ses_pkg::COUNT_RESET;
      column_count_r <= ses_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ses_pkg::REG_ROW_COUNT) begin
        row_count_r <= cfg_data;
      end else if (cfg_index == ses_pkg::REG_COLUMN_COUNT) begin
        column_count_r <= cfg_data;
      end
    end
  end

  // Request, scan index and result payload
  assign total_wide = TWX'(total_r);

  always_ff @(posedge clk) begin
    idx_r        <= cnt_r[AW-1:0];
    res_value_r  <= res_value_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    if (in_acc) begin
      mode_r  <= in_mode;
      row_r   <= in_row;
      col_r   <= in_col;
      value_r <= in_value;
    end
    if (load_out) begin
      out_read_value_r  <= res_value_r;
      out_found_r       <= res_found_r;
      out_status_r      <= res_status_r;
      out_entry_total_r <= total_wide[ses_pkg::TOTAL_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_found       = out_found_r;
  assign out_status      = out_status_r;
  assign out_entry_total = out_entry_total_r;

endmodule
